// ----- design/rgba_paeth_residual_filter_top_defines.svh -----
// Assertion macros for the RGBA Paeth residual filter checks.
`ifndef RGBA_PAETH_RESIDUAL_FILTER_TOP_DEFINES_SVH
`define RGBA_PAETH_RESIDUAL_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication (consequent checked after the antecedent), disabled while in reset.
`define RPR_ASSERT_TWO(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ----- design/rpr_pkg.sv -----
// Package: widths, register indexes and the Paeth predictor for the RGBA residual filter.
package rpr_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int WIDTH_W       = 13;
    localparam int HEIGHT_W      = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = 4;
    localparam int PIX_W         = CHAN_W * NUM_CHAN;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [PIX_W-1:0]  t_pix;

    // a = left, b = upper, c = upper-left; ties go to a, then b
    function automatic t_chan paeth_pred(input t_chan a, input t_chan b, input t_chan c);
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic signed [10:0] sc;
        logic signed [10:0] p;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        sa = signed'({3'b000, a});
        sb = signed'({3'b000, b});
        sc = signed'({3'b000, c});
        p  = sa + sb - sc;
        da = p - sa;
        db = p - sb;
        dc = p - sc;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end
        return c;
    endfunction

endpackage

// ----- design/rgba_paeth_residual_filter_top.sv -----
// Top level: RGBA Paeth residual filter with a line store of the previous row.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one RGBA pixel per item in raster
//   order. Output channel (o_valid / i_stall) carries the four byte residuals
//   and o_last_pixel, set on the final pixel of the image.
//   Configuration: i_cfg_we with i_cfg_index / i_cfg_data writes image_width
//   or image_height; any write restarts the image at row 0, column 0.
//   Pixels in the first row or column pass through unchanged.
//   Throughput: one item per cycle while the output is not stalled. The line store is read when an item is
//   accepted and written back when the item moves to the output register, so
//   a pixel in flight is forwarded when a one-pixel-wide image reads it back.
//   Path: an accepted item and its line store read are registered in the s1
//   registers, then the predictor result is registered in the output register.
//   Reset: counters, neighbor registers and valids clear; the size registers
//   return to 1x1. The line store needs no clearing pass.
//   Stall: while i_stall holds a result, an item behind it waits in the
//   predictor stage with o_stall high; nothing is dropped.
module rgba_paeth_residual_filter_top
    import rpr_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CHAN_W-1:0]     i_red,
    input  logic [CHAN_W-1:0]     i_green,
    input  logic [CHAN_W-1:0]     i_blue,
    input  logic [CHAN_W-1:0]     i_alpha,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAN_W-1:0]     o_red_residual,
    output logic [CHAN_W-1:0]     o_green_residual,
    output logic [CHAN_W-1:0]     o_blue_residual,
    output logic [CHAN_W-1:0]     o_alpha_residual,
    output logic                  o_last_pixel
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    t_pix               mem [MAX_WIDTH];
    t_pix               r_rdata;

    logic [CW-1:0]       r_last_col;
    logic [HEIGHT_W-1:0] r_last_row;
    logic [CW-1:0]       r_col;
    logic [HEIGHT_W-1:0] r_row;

    logic                r_s1_valid;
    t_pix                r_s1_pix;
    logic [CW-1:0]       r_s1_col;
    logic                r_s1_border;
    logic                r_s1_last;
    logic                r_fwd;
    t_pix                r_fwd_data;

    t_pix                r_left;
    t_pix                r_ul;

    logic                r_out_valid;
    t_pix                r_out_res;
    logic                r_out_last;

    logic                out_free;
    logic                s1_go;
    logic                in_acc;
    logic                fwd_hit;
    t_pix                in_pix;
    t_pix                up;
    t_pix                n_res;
    logic [EW-1:0]       cfg_w;
    logic [CW-1:0]       cfg_last_col;
    logic [HEIGHT_W-1:0] cfg_last_row;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_acc   = i_valid && !o_stall;
    assign fwd_hit  = s1_go && (r_s1_col == r_col);
    assign in_pix   = {i_alpha, i_blue, i_green, i_red};
    assign up       = r_fwd ? r_fwd_data : r_rdata;

    always_comb begin
        cfg_w = EW'(i_cfg_data[WIDTH_W-1:0]);
        if (cfg_w == '0) begin
            cfg_w = EW'(1);
        end else if (cfg_w > EW'(MAX_WIDTH)) begin
            cfg_w = EW'(MAX_WIDTH);
        end
        cfg_last_col = CW'(cfg_w - EW'(1));
        cfg_last_row = (i_cfg_data[HEIGHT_W-1:0] == '0) ? '0
                                                         : i_cfg_data[HEIGHT_W-1:0] - 1'b1;
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            if (r_s1_border) begin
                n_res[ch*CHAN_W +: CHAN_W] = r_s1_pix[ch*CHAN_W +: CHAN_W];
            end else begin
                n_res[ch*CHAN_W +: CHAN_W] = r_s1_pix[ch*CHAN_W +: CHAN_W]
                    - paeth_pred(r_left[ch*CHAN_W +: CHAN_W],
                                 up[ch*CHAN_W +: CHAN_W],
                                 r_ul[ch*CHAN_W +: CHAN_W]);
            end
        end
    end

    // line store: read on accept, write back on commit
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            mem[r_s1_col] <= r_s1_pix;
        end
        if (in_acc) begin
            r_rdata <= mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col  <= '0;
            r_last_row  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_ul        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_IMAGE_WIDTH:  r_last_col <= cfg_last_col;
                    REG_IMAGE_HEIGHT: r_last_row <= cfg_last_row;
                    default:          r_last_col <= r_last_col;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                if (r_col == r_last_col) begin
                    r_col <= '0;
                    r_row <= (r_row == r_last_row) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_left      <= r_s1_pix;
                r_ul        <= up;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix    <= in_pix;
            r_s1_col    <= r_col;
            r_s1_border <= (r_col == '0) || (r_row == '0);
            r_s1_last   <= (r_col == r_last_col) && (r_row == r_last_row);
            r_fwd       <= fwd_hit;
            r_fwd_data  <= r_s1_pix;
        end
        if (s1_go) begin
            r_out_res  <= n_res;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_red_residual   = r_out_res[0*CHAN_W +: CHAN_W];
    assign o_green_residual = r_out_res[1*CHAN_W +: CHAN_W];
    assign o_blue_residual  = r_out_res[2*CHAN_W +: CHAN_W];
    assign o_alpha_residual = r_out_res[3*CHAN_W +: CHAN_W];
    assign o_last_pixel     = r_out_last;

endmodule

// ----- design/rpr_checker.sv -----
// Port-level checker for the RGBA Paeth residual filter, bound to the top level.
`include "rgba_paeth_residual_filter_top_defines.svh"

module rpr_checker
    import rpr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CHAN_W-1:0] o_red_residual,
    input logic [CHAN_W-1:0] o_alpha_residual,
    input logic              o_last_pixel
);

    // a held result keeps its payload
    `RPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_red_residual) && $stable(o_alpha_residual) && $stable(o_last_pixel),
        "stalled result changed")

    // input side only backs up behind a stalled output
    `RPR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall,
        o_valid && i_stall, "input stalled without a stalled result")

    // an accepted item leaves o_valid high once it has passed the s1 and output registers
    `RPR_ASSERT_TWO(a_latency, i_clk, i_rst_n, i_valid && !o_stall,
        o_valid, "accepted item produced no result")

endmodule

bind rgba_paeth_residual_filter_top rpr_checker u_rpr_checker (.*);
